FILE: src/bpcr_pkg.sv
// Shared types and constants of the buffer pool clock replacement engine.
package bpcr_pkg;

  localparam int NUM_BUFFERS_DEF = 32;
  localparam int SWEEP_ROUNDS    = 2;
  localparam logic [7:0] PIN_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_PIN   = 2'd1,
    OP_UNPIN = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SWEEP_RD,
    S_SWEEP_EV,
    S_FLUSH_RD,
    S_FLUSH_EV,
    S_UPD_RD,
    S_UPD_WR,
    S_RESULT
  } state_t;

  // Row update selected in the shared row unit.
  typedef enum logic [2:0] {
    MODE_PIN,
    MODE_UNPIN,
    MODE_CLEAR_REF,
    MODE_FLUSH,
    MODE_FILL
  } mode_t;

  typedef struct packed {
    logic [15:0] file;
    logic [31:0] origin;
    logic [7:0]  pin;
    logic        refb;
  } row_t;

  typedef struct packed {
    logic match;      // file id and origin both equal
    logic empty;      // file id zero
    logic file_hit;   // file id equal, for flush
    logic unpinned;   // pin count zero
    logic ref_set;
  } row_stat_t;

endpackage

FILE: src/bpcr_if.sv
// Request and response channel interfaces of the buffer pool engine.
interface bpcr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] file_id;
  logic [31:0] origin;
  logic [4:0]  slot_index;

  modport source (output valid, op, file_id, origin, slot_index, input ready);
  modport sink   (input valid, op, file_id, origin, slot_index, output ready);
endinterface

interface bpcr_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot;
  logic       hit;
  logic       needs_fill;
  logic       failed;

  modport source (output valid, slot, hit, needs_fill, failed, input ready);
  modport sink   (input valid, slot, hit, needs_fill, failed, output ready);
endinterface

FILE: src/bpcr_store.sv
// Entry row memory with per-entry valid bits and registered read.
module bpcr_store #(
  parameter int NUM_BUFFERS = bpcr_pkg::NUM_BUFFERS_DEF,
  localparam int AW = $clog2(NUM_BUFFERS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [AW-1:0]     rd_addr,
  output bpcr_pkg::row_t    rd_row,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  bpcr_pkg::row_t    wr_row
);

  bpcr_pkg::row_t mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] valid;
  bpcr_pkg::row_t rd_raw;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_raw <= mem[rd_addr];
    rd_vld <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // An entry never written reads as empty, unpinned, reference clear.
  always_comb begin
    rd_row = rd_raw;
    if (!rd_vld) begin
      rd_row.file = '0;
      rd_row.pin  = '0;
      rd_row.refb = 1'b0;
    end
  end

endmodule

FILE: src/bpcr_row_unit.sv
// Shared compare and update unit for one entry row.
module bpcr_row_unit (
  input  bpcr_pkg::row_t      row,
  input  bpcr_pkg::mode_t     mode,
  input  logic [15:0]         file_id,
  input  logic [31:0]         origin,
  output bpcr_pkg::row_stat_t stat,
  output bpcr_pkg::row_t      new_row
);

  logic [7:0] pin_inc;
  logic [7:0] pin_dec;

  assign pin_inc = (row.pin == bpcr_pkg::PIN_MAX) ? row.pin : row.pin + 8'd1;
  assign pin_dec = (row.pin == 8'd0) ? row.pin : row.pin - 8'd1;

  always_comb begin
    stat.match    = (row.file == file_id) && (row.origin == origin);
    stat.empty    = (row.file == 16'd0);
    stat.file_hit = (row.file == file_id);
    stat.unpinned = (row.pin == 8'd0);
    stat.ref_set  = row.refb;
  end

  always_comb begin
    new_row = row;
    unique case (mode)
      bpcr_pkg::MODE_PIN: begin
        new_row.pin  = pin_inc;
        new_row.refb = 1'b1;
      end
      bpcr_pkg::MODE_UNPIN: begin
        new_row.pin = pin_dec;
      end
      bpcr_pkg::MODE_CLEAR_REF: begin
        new_row.refb = 1'b0;
      end
      bpcr_pkg::MODE_FLUSH: begin
        new_row.file = 16'd0;
      end
      bpcr_pkg::MODE_FILL: begin
        new_row.file   = file_id;
        new_row.origin = origin;
        new_row.pin    = pin_inc;
        new_row.refb   = 1'b1;
      end
      default: begin
        new_row = row;
      end
    endcase
  end

endmodule

FILE: src/buffer_pool_clock_replacement.sv
// Top level of the buffer pool clock replacement engine: sequencer and result register.
//
// Tag and replacement engine for a pool of NUM_BUFFERS file buffers, one request
// beat at a time. All entry state sits in one row memory read one entry at a time;
// each entry visited is read, then evaluated and written back through a single
// shared row unit. A find that meets neither a hit nor a free entry runs the clock
// sweep for at most its full two rounds before it fails. The request side is ready
// only while the sequencer is idle; a finished result waits in an output register,
// so the next request is accepted while the previous response beat is still
// pending. Reset clears all entries at once through per-entry valid bits, so there
// is no clearing pass.
module buffer_pool_clock_replacement #(
  parameter int NUM_BUFFERS = bpcr_pkg::NUM_BUFFERS_DEF
) (
  input logic        clk,
  input logic        rst,
  bpcr_req_if.sink   req,
  bpcr_rsp_if.source rsp
);

  localparam int AW = $clog2(NUM_BUFFERS);
  localparam int SWEEP_LEN = bpcr_pkg::SWEEP_ROUNDS * NUM_BUFFERS;
  localparam int CW = $clog2(SWEEP_LEN);
  localparam logic [AW-1:0] IDX_LAST = AW'(NUM_BUFFERS - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(SWEEP_LEN - 1);

  bpcr_pkg::state_t state, state_next;
  bpcr_pkg::mode_t  mode, mode_next, unit_mode;

  // Request fields held for the duration of the operation.
  logic [15:0] fid, fid_next;
  logic [31:0] org, org_next;

  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] hand, hand_next;
  logic [AW-1:0] target, target_next;
  logic [AW-1:0] empty_slot, empty_slot_next;
  logic          have_empty, have_empty_next;
  logic [CW-1:0] cnt, cnt_next;

  // Result under construction and the output register.
  logic [4:0] res_slot, res_slot_next;
  logic       res_hit, res_hit_next;
  logic       res_fill, res_fill_next;
  logic       res_fail, res_fail_next;
  logic       out_valid, out_valid_next;
  logic [4:0] out_slot;
  logic       out_hit, out_fill, out_fail;
  logic       out_load;

  logic [AW-1:0]       rd_addr;
  bpcr_pkg::row_t      rd_row;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  bpcr_pkg::row_t      new_row;
  bpcr_pkg::row_stat_t stat;

  bpcr_store #(.NUM_BUFFERS(NUM_BUFFERS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (new_row)
  );

  bpcr_row_unit u_row (
    .row     (rd_row),
    .mode    (unit_mode),
    .file_id (fid),
    .origin  (org),
    .stat    (stat),
    .new_row (new_row)
  );

  assign req.ready = (state == bpcr_pkg::S_IDLE);

  // Pick the read address for the entry the next evaluate step looks at.
  always_comb begin
    unique case (state)
      bpcr_pkg::S_SWEEP_RD: rd_addr = hand;
      bpcr_pkg::S_UPD_RD:   rd_addr = target;
      default:              rd_addr = idx;
    endcase
  end

  // The sweep and flush steps fix their own update; the rest use the latched mode.
  always_comb begin
    unique case (state)
      bpcr_pkg::S_SWEEP_EV: unit_mode = bpcr_pkg::MODE_CLEAR_REF;
      bpcr_pkg::S_FLUSH_EV: unit_mode = bpcr_pkg::MODE_FLUSH;
      default:              unit_mode = mode;
    endcase
  end

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    fid_next        = fid;
    org_next        = org;
    idx_next        = idx;
    hand_next       = hand;
    target_next     = target;
    empty_slot_next = empty_slot;
    have_empty_next = have_empty;
    cnt_next        = cnt;
    res_slot_next   = res_slot;
    res_hit_next    = res_hit;
    res_fill_next   = res_fill;
    res_fail_next   = res_fail;
    wr_en           = 1'b0;
    wr_addr         = idx;
    out_load        = 1'b0;
    out_valid_next  = out_valid && !rsp.ready;

    unique case (state)
      bpcr_pkg::S_IDLE: begin
        if (req.valid) begin
          fid_next        = req.file_id;
          org_next        = req.origin;
          idx_next        = '0;
          have_empty_next = 1'b0;
          res_slot_next   = 5'd0;
          res_hit_next    = 1'b0;
          res_fill_next   = 1'b0;
          res_fail_next   = 1'b0;
          unique case (bpcr_pkg::op_t'(req.op))
            bpcr_pkg::OP_FIND: begin
              // File id zero is reserved for empty entries: fail at once.
              if (req.file_id == 16'd0) begin
                res_fail_next = 1'b1;
                state_next    = bpcr_pkg::S_RESULT;
              end else begin
                state_next = bpcr_pkg::S_SCAN_RD;
              end
            end
            bpcr_pkg::OP_FLUSH: begin
              state_next = bpcr_pkg::S_FLUSH_RD;
            end
            bpcr_pkg::OP_PIN, bpcr_pkg::OP_UNPIN: begin
              res_slot_next = req.slot_index;
              mode_next     = (bpcr_pkg::op_t'(req.op) == bpcr_pkg::OP_PIN) ?
                              bpcr_pkg::MODE_PIN : bpcr_pkg::MODE_UNPIN;
              target_next   = AW'(req.slot_index);
              // Slot beyond the pool: report it and change nothing.
              if (32'(req.slot_index) < NUM_BUFFERS) begin
                state_next = bpcr_pkg::S_UPD_RD;
              end else begin
                state_next = bpcr_pkg::S_RESULT;
              end
            end
            default: begin
              state_next = bpcr_pkg::S_RESULT;
            end
          endcase
        end
      end

      bpcr_pkg::S_SCAN_RD: begin
        state_next = bpcr_pkg::S_SCAN_EV;
      end

      bpcr_pkg::S_SCAN_EV: begin
        if (stat.match) begin
          // Lowest matching entry is a hit: pin it.
          target_next   = idx;
          mode_next     = bpcr_pkg::MODE_PIN;
          res_slot_next = 5'(idx);
          res_hit_next  = 1'b1;
          state_next    = bpcr_pkg::S_UPD_RD;
        end else begin
          if (stat.empty) begin
            have_empty_next = 1'b1;
            empty_slot_next = idx;
          end
          if (idx == IDX_LAST) begin
            if (stat.empty || have_empty) begin
              // Highest-numbered empty entry takes the fill.
              target_next   = stat.empty ? idx : empty_slot;
              mode_next     = bpcr_pkg::MODE_FILL;
              res_slot_next = 5'(stat.empty ? idx : empty_slot);
              res_fill_next = 1'b1;
              state_next    = bpcr_pkg::S_UPD_RD;
            end else begin
              cnt_next   = '0;
              state_next = bpcr_pkg::S_SWEEP_RD;
            end
          end else begin
            idx_next   = idx + AW'(1);
            state_next = bpcr_pkg::S_SCAN_RD;
          end
        end
      end

      bpcr_pkg::S_SWEEP_RD: begin
        state_next = bpcr_pkg::S_SWEEP_EV;
      end

      bpcr_pkg::S_SWEEP_EV: begin
        if (stat.unpinned && !stat.ref_set) begin
          // Victim found: the hand stays on it.
          target_next   = hand;
          mode_next     = bpcr_pkg::MODE_FILL;
          res_slot_next = 5'(hand);
          res_fill_next = 1'b1;
          state_next    = bpcr_pkg::S_UPD_RD;
        end else begin
          // Second chance: clear the reference bit of an unpinned entry.
          if (stat.unpinned) begin
            wr_en   = 1'b1;
            wr_addr = hand;
          end
          hand_next = (hand == IDX_LAST) ? '0 : hand + AW'(1);
          if (cnt == CNT_LAST) begin
            res_fail_next = 1'b1;
            state_next    = bpcr_pkg::S_RESULT;
          end else begin
            cnt_next   = cnt + CW'(1);
            state_next = bpcr_pkg::S_SWEEP_RD;
          end
        end
      end

      bpcr_pkg::S_FLUSH_RD: begin
        state_next = bpcr_pkg::S_FLUSH_EV;
      end

      bpcr_pkg::S_FLUSH_EV: begin
        if (stat.file_hit) begin
          wr_en   = 1'b1;
          wr_addr = idx;
        end
        if (idx == IDX_LAST) begin
          state_next = bpcr_pkg::S_RESULT;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = bpcr_pkg::S_FLUSH_RD;
        end
      end

      bpcr_pkg::S_UPD_RD: begin
        state_next = bpcr_pkg::S_UPD_WR;
      end

      bpcr_pkg::S_UPD_WR: begin
        wr_en      = 1'b1;
        wr_addr    = target;
        state_next = bpcr_pkg::S_RESULT;
      end

      bpcr_pkg::S_RESULT: begin
        // Hold until the output register is free.
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = bpcr_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bpcr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpcr_pkg::S_IDLE;
      hand      <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      hand      <= hand_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    mode       <= mode_next;
    fid        <= fid_next;
    org        <= org_next;
    idx        <= idx_next;
    target     <= target_next;
    empty_slot <= empty_slot_next;
    have_empty <= have_empty_next;
    res_slot   <= res_slot_next;
    res_hit    <= res_hit_next;
    res_fill   <= res_fill_next;
    res_fail   <= res_fail_next;
    if (out_load) begin
      out_slot <= res_slot;
      out_hit  <= res_hit;
      out_fill <= res_fill;
      out_fail <= res_fail;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.slot       = out_slot;
  assign rsp.hit        = out_hit;
  assign rsp.needs_fill = out_fill;
  assign rsp.failed     = out_fail;

  // A result beat reports at most one of hit, fill and failure.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $onehot0({rsp.hit, rsp.needs_fill, rsp.failed}))
    else $error("response beat carries more than one outcome flag");

  // The sequencer leaves idle on every accepted request beat.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request side still ready after accepting a beat");

  // The sweep never runs past two rounds of the pool.
  assert property (@(posedge clk) disable iff (rst)
    (state == bpcr_pkg::S_SWEEP_EV) |-> (cnt <= CNT_LAST))
    else $error("clock sweep ran past its limit");

  // A row update always targets an entry inside the pool.
  assert property (@(posedge clk) disable iff (rst)
    (state == bpcr_pkg::S_UPD_WR) |-> (32'(target) < NUM_BUFFERS))
    else $error("row update targets an entry outside the pool");

endmodule

FILE: sim/buffer_pool_clock_replacement_test.sv
// Self-checking testbench for the buffer pool clock replacement engine.
`timescale 1ns / 100ps

module buffer_pool_clock_replacement_test;

  localparam int POOL_SIZE   = bpcr_pkg::NUM_BUFFERS_DEF;
  // Longest quiet stretch: a full receiver hold-off plus a worst-case sweep,
  // with plenty of margin for random stalls on top.
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  // Wait at the end for longer than a full two-round sweep takes.
  localparam int TAIL_CYCLES = 250;
  localparam int PHASE_BEATS = 110;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       needs_fill;
    logic       failed;
  } lookup_result_t;

  // Shadow copy of the tag and policy state plus the queue of responses
  // still owed by the block.
  class pool_shadow;
    bit [15:0]      file_of   [POOL_SIZE];
    bit [31:0]      origin_of [POOL_SIZE];
    bit [7:0]       pins      [POOL_SIZE];
    bit             ref_of    [POOL_SIZE];
    int             hand;
    lookup_result_t pending [$];
    lookup_result_t last;
    int             errors;

    function void grab(int s);
      if (pins[s] != bpcr_pkg::PIN_MAX) pins[s]++;
      ref_of[s] = 1'b1;
    endfunction

    // Second-chance sweep; on failure the hand ends where it started.
    function bit pick_victim(output int victim);
      int n;
      victim = 0;
      for (n = 0; n < bpcr_pkg::SWEEP_ROUNDS * POOL_SIZE; n++) begin
        if (pins[hand] == 0) begin
          if (ref_of[hand]) begin
            ref_of[hand] = 1'b0;
          end else begin
            victim = hand;
            return 1'b1;
          end
        end
        hand = (hand + 1) % POOL_SIZE;
      end
      return 1'b0;
    endfunction

    function void note_request(bpcr_pkg::op_t op, bit [15:0] fid, bit [31:0] org,
                               bit [4:0] idx);
      lookup_result_t r;
      bit             have_empty;
      int             target;
      int             found;
      int             victim;
      int             i;
      r          = '0;
      have_empty = 1'b0;
      target     = 0;
      found      = -1;
      case (op)
        bpcr_pkg::OP_FIND: begin
          if (fid == 16'h0000) begin
            r.failed = 1'b1;
          end else begin
            for (i = 0; i < POOL_SIZE; i++) begin
              if (found < 0 && file_of[i] == fid && origin_of[i] == org) found = i;
              if (file_of[i] == 16'h0000) begin
                have_empty = 1'b1;
                target     = i;
              end
            end
            if (found >= 0) begin
              grab(found);
              r.slot = found[4:0];
              r.hit  = 1'b1;
            end else begin
              if (!have_empty && pick_victim(victim)) begin
                have_empty = 1'b1;
                target     = victim;
              end
              if (have_empty) begin
                file_of[target]   = fid;
                origin_of[target] = org;
                grab(target);
                r.slot       = target[4:0];
                r.needs_fill = 1'b1;
              end else begin
                r.failed = 1'b1;
              end
            end
          end
        end
        bpcr_pkg::OP_FLUSH: begin
          for (i = 0; i < POOL_SIZE; i++)
            if (file_of[i] == fid) file_of[i] = 16'h0000;
        end
        default: begin
          if (int'(idx) < POOL_SIZE) begin
            if (op == bpcr_pkg::OP_PIN) grab(int'(idx));
            else if (pins[idx] != 0) pins[idx]--;
          end
          r.slot = idx;
        end
      endcase
      pending.push_back(r);
      last = r;
    endfunction

    function void check_response(lookup_result_t got);
      lookup_result_t want;
      if (pending.size() == 0) begin
        $error("response beat with nothing outstanding: slot %0d", got.slot);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, got %0b", want.hit, got.hit);
        errors++;
      end
      if (got.needs_fill !== want.needs_fill) begin
        $error("needs_fill: expected %0b, got %0b", want.needs_fill, got.needs_fill);
        errors++;
      end
      if (got.failed !== want.failed) begin
        $error("failed: expected %0b, got %0b", want.failed, got.failed);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bpcr_req_if req_ch ();
  bpcr_rsp_if rsp_ch ();

  buffer_pool_clock_replacement u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pool_shadow shadow;
  int         send_idle_pct;
  int         stall_pct;
  int         beats_sent;
  int         hold_reqs;
  int         quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Response side: drive ready at the falling edge. A hold request from the
  // stimulus thread parks ready low for a long stretch, counted here.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Check every response beat at the rising edge against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      shadow.check_response(lookup_result_t'({rsp_ch.slot, rsp_ch.hit,
                                              rsp_ch.needs_fill, rsp_ch.failed}));
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request beat; called and returning at a falling edge. Insert
  // random idle cycles first, then hold valid until the block takes the beat.
  task automatic issue(bpcr_pkg::op_t op, logic [15:0] fid, logic [31:0] org,
                       logic [4:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.file_id    <= fid;
    req_ch.origin     <= org;
    req_ch.slot_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.note_request(op, fid, org, idx);
    beats_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted response has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (shadow.pending.size() != 0) @(negedge clk);
  endtask

  // Keys: mostly a small set so finds hit and flushes bite, sometimes wide.
  function automatic logic [15:0] pick_file();
    if ($urandom_range(0, 99) < 80) return 16'($urandom_range(1, 6));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_origin();
    if ($urandom_range(0, 99) < 80) return 32'($urandom_range(0, 9)) << 12;
    return 32'($urandom);
  endfunction

  // Unpin every entry down to zero so the sweep has victims again.
  task automatic release_all();
    int s;
    for (s = 0; s < POOL_SIZE; s++)
      while (shadow.pins[s] != 0)
        issue(bpcr_pkg::OP_UNPIN, 16'($urandom), 32'($urandom), 5'(s));
  endtask

  // Pin more fresh keys than the pool holds: the sweep evicts whatever is
  // unpinned, then finds fail once every entry is pinned.
  task automatic pin_whole_pool();
    repeat (POOL_SIZE + 2)
      issue(bpcr_pkg::OP_FIND, 16'($urandom_range(1, 65535)), 32'($urandom),
            5'($urandom));
    release_all();
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 999);
    if (r < 600) begin
      // find, then usually hand the entry back as a user would
      issue(bpcr_pkg::OP_FIND, pick_file(), pick_origin(), 5'($urandom));
      if (!shadow.last.failed && $urandom_range(0, 99) < 85)
        issue(bpcr_pkg::OP_UNPIN, 16'($urandom), 32'($urandom), shadow.last.slot);
    end else if (r < 700) begin
      issue(bpcr_pkg::OP_PIN, 16'($urandom), 32'($urandom), 5'($urandom));
    end else if (r < 820) begin
      issue(bpcr_pkg::OP_UNPIN, 16'($urandom), 32'($urandom), 5'($urandom));
    end else if (r < 900) begin
      issue(bpcr_pkg::OP_FLUSH, pick_file(), 32'($urandom), 5'($urandom));
    end else if (r < 985) begin
      issue(bpcr_pkg::OP_FIND, 16'h0000, 32'($urandom), 5'($urandom));
    end else begin
      pin_whole_pool();
    end
  endtask

  task automatic run_random(int beats);
    int start;
    start = beats_sent;
    while (beats_sent - start < beats) random_step();
  endtask

  task automatic directed();
    issue(bpcr_pkg::OP_FIND,  16'h0000, 32'hFFFF_FFFF, 5'h1F);  // reserved id fails
    issue(bpcr_pkg::OP_FIND,  16'hFFFF, 32'hFFFF_FFFF, 5'h00);  // fill highest empty
    issue(bpcr_pkg::OP_FIND,  16'hFFFF, 32'hFFFF_FFFF, 5'h00);  // hit, pin count two
    issue(bpcr_pkg::OP_FIND,  16'hFFFF, 32'h0000_0000, 5'h00);  // same file, other origin
    issue(bpcr_pkg::OP_FIND,  16'h0001, 32'h0000_0000, 5'h00);
    issue(bpcr_pkg::OP_PIN,   16'h0000, 32'h0000_0000, 5'h00);  // pin an empty entry
    issue(bpcr_pkg::OP_UNPIN, 16'h0000, 32'h0000_0000, 5'h00);
    issue(bpcr_pkg::OP_UNPIN, 16'h0000, 32'h0000_0000, 5'h00);  // unpin at zero holds
    issue(bpcr_pkg::OP_FLUSH, 16'h0000, 32'h0000_0000, 5'h00);  // empty id: no change
    issue(bpcr_pkg::OP_FLUSH, 16'hFFFF, 32'hFFFF_FFFF, 5'h1F);  // empty both entries
    issue(bpcr_pkg::OP_FIND,  16'h8000, 32'h8000_0000, 5'h00);  // refill keeps pin count
    issue(bpcr_pkg::OP_FIND,  16'hFFFF, 32'hFFFF_FFFF, 5'h00);  // flushed key misses
    repeat (3) issue(bpcr_pkg::OP_UNPIN, 16'h0000, 32'h0000_0000, 5'h1F);
    repeat (2) issue(bpcr_pkg::OP_UNPIN, 16'h0000, 32'h0000_0000, 5'h1E);
    issue(bpcr_pkg::OP_UNPIN, 16'h0000, 32'h0000_0000, 5'h1D);
    issue(bpcr_pkg::OP_FIND,  16'h0001, 32'h0000_0000, 5'h00);  // hit on the survivor
    issue(bpcr_pkg::OP_PIN,   16'hFFFF, 32'hFFFF_FFFF, 5'h1F);
    issue(bpcr_pkg::OP_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 5'h1F);
  endtask

  initial begin
    shadow            = new();
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.op         = bpcr_pkg::OP_FIND;
    req_ch.file_id    = '0;
    req_ch.origin     = '0;
    req_ch.slot_index = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    beats_sent        = 0;
    hold_reqs         = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed();
    drain();
    release_all();
    drain();

    // back-to-back traffic
    run_random(PHASE_BEATS);
    drain();

    // sender idles; first park the receiver so the block fills and stalls
    send_idle_pct = 59;
    stall_pct     = 0;
    hold_reqs++;
    repeat (12) issue(bpcr_pkg::OP_FIND, pick_file(), pick_origin(), 5'($urandom));
    release_all();
    run_random(PHASE_BEATS);
    drain();

    // receiver stalls
    send_idle_pct = 0;
    stall_pct     = 59;
    run_random(PHASE_BEATS);
    drain();

    // light idling on both sides
    send_idle_pct = 9;
    stall_pct     = 9;
    run_random(PHASE_BEATS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.pending.size() != 0) begin
      $error("%0d responses never arrived", shadow.pending.size());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
